### rtl/core/assert_macros.svh
// Assertion macros shared by the envelope RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, masked while reset is asserted.
`define TLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define TLE_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLE_ASSERT(lbl, prop, msg)
`define TLE_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

### rtl/core/tle_pkg.sv
// Shared types and constants for the trapezoid light envelope.
`default_nettype none
package tle_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned TIME_W = 24;
	localparam int unsigned STAMP_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FALL       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd7;

	localparam logic [2:0] MODE_CONST    = 3'd0;
	localparam logic [2:0] MODE_ONE_WAY  = 3'd1;
	localparam logic [2:0] MODE_ONE_TIME = 3'd2;
	localparam logic [2:0] MODE_LOOP_NOW = 3'd3;
	localparam logic [2:0] MODE_LOOP_PER = 3'd4;

	localparam logic [1:0] PH_DELAY = 2'd0;
	localparam logic [1:0] PH_RISE  = 2'd1;
	localparam logic [1:0] PH_HOLD  = 2'd2;
	localparam logic [1:0] PH_FALL  = 2'd3;

	typedef struct packed {
		logic [2:0]         mode;
		logic [LEVEL_W-1:0] level_low;
		logic [LEVEL_W-1:0] level_high;
		logic [TIME_W-1:0]  delay_time;
		logic [TIME_W-1:0]  rise_time;
		logic [TIME_W-1:0]  hold_time;
		logic [TIME_W-1:0]  fall_time;
		logic [TIME_W-1:0]  period;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [LEVEL_W-1:0] mag;
		logic [TIME_W-1:0]  offset;
		logic [TIME_W-1:0]  span;
	} ramp_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRAP,
		S_PHASE,
		S_RAMP,
		S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		R_IDLE,
		R_MUL,
		R_DIV
	} ramp_state_t;

endpackage
`default_nettype wire

### rtl/core/tle_cfg.sv
// Configuration register bank for the envelope.
`default_nettype none
module tle_cfg (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              wr_en,
	input  wire  [tle_pkg::CFG_IDX_W-1:0]    wr_idx,
	input  wire  [tle_pkg::CFG_DATA_W-1:0]   wr_data,
	output tle_pkg::cfg_t                    cfg
);
	import tle_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_CONST;
			cfg_q.level_low  <= '0;
			cfg_q.level_high <= '1;
			cfg_q.delay_time <= '0;
			cfg_q.rise_time  <= '0;
			cfg_q.hold_time  <= '0;
			cfg_q.fall_time  <= '0;
			cfg_q.period     <= TIME_W'(1000);
		end else if (wr_en) begin
			unique case (wr_idx)
				CFG_MODE:       cfg_q.mode       <= wr_data[2:0];
				CFG_LEVEL_LOW:  cfg_q.level_low  <= wr_data[LEVEL_W-1:0];
				CFG_LEVEL_HIGH: cfg_q.level_high <= wr_data[LEVEL_W-1:0];
				CFG_DELAY:      cfg_q.delay_time <= wr_data[TIME_W-1:0];
				CFG_RISE:       cfg_q.rise_time  <= wr_data[TIME_W-1:0];
				CFG_HOLD:       cfg_q.hold_time  <= wr_data[TIME_W-1:0];
				CFG_FALL:       cfg_q.fall_time  <= wr_data[TIME_W-1:0];
				CFG_PERIOD:     cfg_q.period     <= wr_data[TIME_W-1:0];
				default:        ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### rtl/core/tle_ramp.sv
// Ramp step unit: one multiply, then a 16-step restoring divide.
`default_nettype none
`include "assert_macros.svh"
module tle_ramp (
	input  wire                            clk,
	input  wire                            arst_n,
	input  tle_pkg::ramp_req_t             req,
	output logic                           done,
	output logic [tle_pkg::LEVEL_W-1:0]    quot
);
	import tle_pkg::*;

	localparam int unsigned PROD_W = LEVEL_W + TIME_W;
	localparam int unsigned CNT_W = $clog2(LEVEL_W);

	ramp_state_t state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [LEVEL_W-1:0] mag_q;
	logic [TIME_W-1:0]  off_q;
	logic [TIME_W-1:0]  span_q;
	logic [TIME_W-1:0]  rem_q;
	logic [LEVEL_W-1:0] low_q;

	logic [PROD_W-1:0]  prod;
	logic [TIME_W:0]    trial;
	logic [TIME_W:0]    sub;
	logic               qbit;
	logic               last;

	assign prod  = {{TIME_W{1'b0}}, mag_q} * {{LEVEL_W{1'b0}}, off_q};
	assign trial = {rem_q, low_q[LEVEL_W-1]};
	assign sub   = trial - {1'b0, span_q};
	assign qbit  = ~sub[TIME_W];
	assign last  = (cnt_q == CNT_W'(LEVEL_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == R_DIV) && last;
			if (state_q == R_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				if (req.start) begin
					mag_q  <= req.mag;
					off_q  <= req.offset;
					span_q <= req.span;
				end
			end
			R_MUL: begin
				rem_q <= prod[PROD_W-1:LEVEL_W];
				low_q <= prod[LEVEL_W-1:0];
			end
			R_DIV: begin
				rem_q <= qbit ? sub[TIME_W-1:0] : trial[TIME_W-1:0];
				low_q <= {low_q[LEVEL_W-2:0], qbit};
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			R_IDLE: if (req.start) state_d = R_MUL;
			R_MUL:  state_d = R_DIV;
			R_DIV:  if (last) state_d = R_IDLE;
			default: state_d = R_IDLE;
		endcase
	end

	assign done = done_q;
	assign quot = low_q;

	`TLE_ASSERT(a_rem_below_span, (state_q == R_DIV) |-> (rem_q < span_q), "remainder not below span")
	`TLE_ASSERT(a_done_after_div, done_q |-> $past(state_q == R_DIV), "done without divide")
	`TLE_ASSERT(a_start_when_idle, req.start |-> (state_q == R_IDLE), "start while busy")

endmodule
`default_nettype wire

### rtl/core/trapezoid_light_envelope.sv
// Top level: sequencer, start time, output register of the light envelope.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    now_time[31:0], restart
//   out      source     out_valid / out_ready  level[15:0]
//   cfg      sink       cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[23:0]
//
// A transaction passes the loop wrap step, then, outside the flat modes and unless
// now_time lies before the start time, one to four phase compares on the shared adder,
// and on a ramp one multiply and 16 restoring-divide steps in the ramp unit.
// The output register lets a new transaction in while a level waits on out_ready;
// a finished level stalls in the sequencer only if that register is still full.
// Reset clears start time and config to defaults; cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"
module trapezoid_light_envelope (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [tle_pkg::STAMP_W-1:0]       now_time,
	input  wire                               restart,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [tle_pkg::LEVEL_W-1:0]       level,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [tle_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [tle_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tle_pkg::*;

	localparam int unsigned BND_W = TIME_W + 2;

	cfg_t      cfg;
	ramp_req_t ramp_req;
	logic      ramp_done;
	logic [LEVEL_W-1:0] ramp_quot;

	seq_state_t state_q, state_d;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] start_q;
	logic [STAMP_W-1:0] dt_q;
	logic [1:0]         ph_q;
	logic [BND_W-1:0]   bnd_q;
	logic [BND_W-1:0]   prev_q;
	logic               fall_q;
	logic [LEVEL_W-1:0] res_q;
	logic [LEVEL_W-1:0] from_q;
	logic               neg_q;
	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_q;

	logic               in_acc;
	logic               out_load;
	logic [STAMP_W-1:0] start_sel;
	logic               flat_mode;
	logic               wrap;
	logic               lt;
	logic [TIME_W-1:0]  next_len;
	logic               ramp_go;
	logic [LEVEL_W-1:0] ramp_from;
	logic [LEVEL_W-1:0] ramp_to;
	logic               ramp_neg;

	tle_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid & cfg_ready),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	tle_ramp u_ramp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ramp_req),
		.done   (ramp_done),
		.quot   (ramp_quot)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign start_sel = restart ? now_time : start_q;
	assign flat_mode = (cfg.mode == MODE_CONST) || (cfg.mode > MODE_LOOP_PER);
	assign wrap      = (cfg.mode != MODE_ONE_WAY) && ({8'd0, cfg.period} < dt_q);
	assign lt        = dt_q < {{(STAMP_W-BND_W){1'b0}}, bnd_q};

	always_comb begin
		unique case (ph_q)
			PH_DELAY: next_len = cfg.rise_time;
			PH_RISE:  next_len = cfg.hold_time;
			default:  next_len = cfg.fall_time;
		endcase
	end

	assign ramp_go = (state_q == S_PHASE) &&
		(((ph_q == PH_RISE) && lt) || ((ph_q == PH_FALL) && lt));
	assign ramp_from = (ph_q == PH_RISE) ? cfg.level_low : cfg.level_high;
	assign ramp_to   = (ph_q == PH_RISE) ? cfg.level_high : cfg.level_low;
	assign ramp_neg  = ramp_to < ramp_from;

	assign ramp_req.start  = ramp_go;
	assign ramp_req.mag    = ramp_neg ? (ramp_from - ramp_to) : (ramp_to - ramp_from);
	assign ramp_req.offset = dt_q[TIME_W-1:0] - prev_q[TIME_W-1:0];
	assign ramp_req.span   = (ph_q == PH_RISE) ? cfg.rise_time : cfg.fall_time;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				start_q <= start_sel;
			end else if ((state_q == S_WRAP) && !flat_mode && !dt_q[STAMP_W-1] && wrap) begin
				if (cfg.mode == MODE_LOOP_NOW) begin
					start_q <= now_q;
				end else if (cfg.mode == MODE_LOOP_PER) begin
					start_q <= start_q + {8'd0, cfg.period};
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			level_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					now_q <= now_time;
					dt_q  <= now_time - start_sel;
				end
			end
			S_WRAP: begin
				fall_q <= (cfg.mode != MODE_ONE_WAY);
				ph_q   <= PH_DELAY;
				prev_q <= '0;
				bnd_q  <= {2'b00, cfg.delay_time};
				if (flat_mode) begin
					res_q <= cfg.level_low;
				end else if (dt_q[STAMP_W-1]) begin
					res_q <= '0;
				end else if (wrap) begin
					if (cfg.mode == MODE_LOOP_NOW) begin
						dt_q <= '0;
					end else if (cfg.mode == MODE_LOOP_PER) begin
						dt_q <= dt_q - {8'd0, cfg.period};
					end
				end
			end
			S_PHASE: begin
				from_q <= ramp_from;
				neg_q  <= ramp_neg;
				prev_q <= bnd_q;
				bnd_q  <= bnd_q + {2'b00, next_len};
				if (!lt) begin
					ph_q <= ph_q + 1'b1;
				end
				unique case (ph_q)
					PH_DELAY: res_q <= cfg.level_low;
					PH_HOLD:  res_q <= cfg.level_high;
					default:  res_q <= cfg.level_low;
				endcase
			end
			S_RAMP: begin
				if (ramp_done) begin
					res_q <= neg_q ? (from_q - ramp_quot) : (from_q + ramp_quot);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_acc) state_d = S_WRAP;
			S_WRAP: begin
				if (flat_mode || dt_q[STAMP_W-1]) begin
					state_d = S_DONE;
				end else begin
					state_d = S_PHASE;
				end
			end
			S_PHASE: begin
				unique case (ph_q)
					PH_DELAY: if (lt) state_d = S_DONE;
					PH_RISE:  if (lt) state_d = S_RAMP;
					PH_HOLD:  if (lt || !fall_q) state_d = S_DONE;
					default:  state_d = lt ? S_RAMP : S_DONE;
				endcase
			end
			S_RAMP: if (ramp_done) state_d = S_DONE;
			S_DONE: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;

	`TLE_ASSERT(a_accept_to_wrap, in_acc |=> (state_q == S_WRAP), "accept did not start sequence")
	`TLE_ASSERT(a_ramp_phase, (state_q == S_RAMP) |-> (ph_q == PH_RISE || ph_q == PH_FALL),
		"ramp outside a ramp phase")
	`TLE_ASSERT(a_done_in_ramp, ramp_done |-> (state_q == S_RAMP), "ramp result unexpected")
	`TLE_ASSERT(a_load_sets_valid, out_load |=> out_valid_q, "loaded level not shown")

endmodule
`default_nettype wire
